FILE: design/tasc_pkg.sv
// Package for the two-axis stepper command sequencer.
// Holds the sequencer mode type, direction and register codes, widths and the coil table.
// No dependencies; imported by two_axis_stepper_command_sequencer_unit.
`default_nettype none

package tasc_pkg;

    localparam int HIST_DEPTH  = 128;
    localparam int HIST_ADDR_W = $clog2(HIST_DEPTH);
    localparam int HIST_CNT_W  = $clog2(HIST_DEPTH + 1);

    localparam int PERIOD_W = 16;
    localparam int STEPS_W  = 12;
    localparam int CHUNK_W  = 8;
    localparam int INDEX_W  = STEPS_W + 1;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_MOVE  = 3'd1,
        MODE_FAST  = 3'd2,
        MODE_RLOAD = 3'd3,
        MODE_RMOVE = 3'd4,
        MODE_HOMEH = 3'd5,
        MODE_HOMEV = 3'd6,
        MODE_LEFT  = 3'd7
    } mode_t;

    typedef logic [1:0] dir_t;
    localparam dir_t DIR_UP    = 2'd0;
    localparam dir_t DIR_DOWN  = 2'd1;
    localparam dir_t DIR_LEFT  = 2'd2;
    localparam dir_t DIR_RIGHT = 2'd3;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_STEP_PERIOD = 3'd0;
    localparam reg_idx_t REG_VERT_STEPS  = 3'd1;
    localparam reg_idx_t REG_HORZ_STEPS  = 3'd2;
    localparam reg_idx_t REG_FULL_WIDTH  = 3'd3;
    localparam reg_idx_t REG_HOME_CHUNK  = 3'd4;

    localparam logic [7:0] CHAR_DOWN   = 8'h64; // 'd'
    localparam logic [7:0] CHAR_UP     = 8'h75; // 'u'
    localparam logic [7:0] CHAR_RIGHT  = 8'h72; // 'r'
    localparam logic [7:0] CHAR_LEFT   = 8'h6C; // 'l'
    localparam logic [7:0] CHAR_REPLAY = 8'h7A; // 'z'
    localparam logic [7:0] CHAR_HOME   = 8'h69; // 'i'

    // Full-step coil patterns, bit 0 posA up to bit 3 negB.
    function automatic logic [3:0] phase_coils(input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0:    pat = 4'd5;
            2'd1:    pat = 4'd6;
            2'd2:    pat = 4'd10;
            default: pat = 4'd9;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

FILE: design/two_axis_stepper_command_sequencer_unit.sv
// Two-axis stepper command sequencer: top level with APB registers, stream ports,
// sequencer state and the move history memory. Depends on tasc_pkg.
//
// Each accepted input transaction (a timer tick or a command byte, with both limit
// switch levels) produces exactly one output transaction holding both coil patterns,
// the driver enable, the acknowledge strobe, the busy flag and the dropped flag.
// The block takes one input transaction per clock cycle while the output is not held back;
// its result is registered in the output register in the cycle after it is accepted, and
// a new input is taken in the same cycle that the previous result is taken. The rate is
// set by the single read-modify-write pass over the sequencer state per cycle; the move
// history memory is read every cycle at the entry below the replay pointer so that its
// registered data is ready when the next tick needs it. No clearing pass is needed after reset.
`default_nettype none

module two_axis_stepper_command_sequencer_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // APB configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tasc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [tasc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [tasc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    // Input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [15:0]                      s_tdata,  // rx_byte[7:0], limit_h, limit_v, zeros
    input  wire logic [0:0]                       s_tuser,  // command
    // Result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [15:0]                      m_tdata   // coils_horizontal[3:0],
                                                            // coils_vertical[3:0], driver_enable,
                                                            // send_ack, busy_res, dropped, zeros
);
    import tasc_pkg::*;

    // Configuration registers
    logic [PERIOD_W-1:0] step_period_reg;
    logic [STEPS_W-1:0]  vert_steps_reg;
    logic [STEPS_W-1:0]  horz_steps_reg;
    logic [STEPS_W-1:0]  full_width_reg;
    logic [CHUNK_W-1:0]  home_chunk_reg;

    // Sequencer state
    mode_t               mode_reg, mode_next;
    dir_t                dir_reg, dir_next;
    logic [INDEX_W-1:0]  step_idx_reg, step_idx_next;
    logic [STEPS_W-1:0]  target_reg, target_next;
    logic [PERIOD_W-1:0] period_cnt_reg, period_cnt_next;
    logic [HIST_CNT_W-1:0] hist_cnt_reg, hist_cnt_next;
    logic [HIST_CNT_W-1:0] replay_ptr_reg, replay_ptr_next;
    logic                pend_ack_reg, pend_ack_next;
    logic [3:0]          coils_h_reg, coils_h_next;
    logic [3:0]          coils_v_reg, coils_v_next;
    logic                enable_reg, enable_next;

    // Output register
    logic                m_valid_reg;
    logic [15:0]         m_data_reg;

    // History memory
    logic [1:0]             hist_mem [HIST_DEPTH];
    logic [1:0]             hist_rd_data_reg;
    logic [HIST_ADDR_W-1:0] hist_rd_addr;
    logic [HIST_ADDR_W-1:0] hist_wr_addr;
    logic                   hist_we;

    logic                cfg_write;
    reg_idx_t            cfg_idx;
    logic                in_accept;
    logic                is_cmd;
    logic [7:0]          rx_byte;
    logic                lim_h;
    logic                lim_v;
    logic                ack;
    logic                drop;
    logic                step_done;
    logic [1:0]          phase;
    logic [3:0]          pat;
    dir_t                replay_dir;
    logic [HIST_CNT_W-1:0] replay_ptr_dec;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_period_reg <= PERIOD_W'(5);
            vert_steps_reg  <= STEPS_W'(178);
            horz_steps_reg  <= STEPS_W'(191);
            full_width_reg  <= STEPS_W'(1720);
            home_chunk_reg  <= CHUNK_W'(10);
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_STEP_PERIOD: step_period_reg <= pwdata[PERIOD_W-1:0];
                REG_VERT_STEPS:  vert_steps_reg  <= pwdata[STEPS_W-1:0];
                REG_HORZ_STEPS:  horz_steps_reg  <= pwdata[STEPS_W-1:0];
                REG_FULL_WIDTH:  full_width_reg  <= pwdata[STEPS_W-1:0];
                REG_HOME_CHUNK:  home_chunk_reg  <= pwdata[CHUNK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_STEP_PERIOD: prdata = APB_DATA_W'(step_period_reg);
            REG_VERT_STEPS:  prdata = APB_DATA_W'(vert_steps_reg);
            REG_HORZ_STEPS:  prdata = APB_DATA_W'(horz_steps_reg);
            REG_FULL_WIDTH:  prdata = APB_DATA_W'(full_width_reg);
            REG_HOME_CHUNK:  prdata = APB_DATA_W'(home_chunk_reg);
            default:         prdata = '0;
        endcase
    end

    // Stream handshake: the output register frees up in the cycle its result is taken.
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign is_cmd    = s_tuser[0];
    assign rx_byte   = s_tdata[7:0];
    assign lim_h     = s_tdata[8];
    assign lim_v     = s_tdata[9];

    assign replay_ptr_dec = replay_ptr_reg - HIST_CNT_W'(1);
    assign replay_dir     = hist_rd_data_reg ^ 2'b01;
    assign phase          = (dir_reg[1] ^ dir_reg[0]) ? ~step_idx_reg[1:0] : step_idx_reg[1:0];
    assign pat            = phase_coils(phase);
    assign step_done      = step_idx_reg > {1'b0, target_reg};

    always_comb begin
        mode_next       = mode_reg;
        dir_next        = dir_reg;
        step_idx_next   = step_idx_reg;
        target_next     = target_reg;
        period_cnt_next = period_cnt_reg;
        hist_cnt_next   = hist_cnt_reg;
        replay_ptr_next = replay_ptr_reg;
        pend_ack_next   = pend_ack_reg;
        coils_h_next    = coils_h_reg;
        coils_v_next    = coils_v_reg;
        enable_next     = enable_reg;
        ack             = 1'b0;
        drop            = 1'b0;
        hist_we         = 1'b0;
        hist_wr_addr    = hist_cnt_reg[HIST_ADDR_W-1:0];

        if (in_accept && is_cmd) begin
            if (mode_reg != MODE_IDLE) begin
                drop = 1'b1;
            end else begin
                pend_ack_next   = 1'b1;
                step_idx_next   = '0;
                period_cnt_next = '0;
                case (rx_byte)
                    CHAR_DOWN: begin
                        mode_next = MODE_MOVE; dir_next = DIR_DOWN; target_next = vert_steps_reg;
                    end
                    CHAR_UP: begin
                        mode_next = MODE_MOVE; dir_next = DIR_UP; target_next = vert_steps_reg;
                    end
                    CHAR_RIGHT: begin
                        mode_next = MODE_MOVE; dir_next = DIR_RIGHT; target_next = horz_steps_reg;
                    end
                    CHAR_LEFT: begin
                        mode_next = MODE_MOVE; dir_next = DIR_LEFT; target_next = horz_steps_reg;
                    end
                    CHAR_REPLAY: begin
                        // Direction, index and target stay as they are until a load.
                        mode_next       = MODE_RLOAD;
                        replay_ptr_next = hist_cnt_reg;
                        step_idx_next   = step_idx_reg;
                    end
                    CHAR_HOME: begin
                        mode_next     = MODE_HOMEH;
                        dir_next      = DIR_RIGHT;
                        target_next   = STEPS_W'(home_chunk_reg);
                        pend_ack_next = 1'b0;
                    end
                    default: begin
                        mode_next     = MODE_FAST;
                        dir_next      = DIR_UP;
                        target_next   = STEPS_W'(3);
                        pend_ack_next = 1'b0;
                    end
                endcase
            end
        end else if (in_accept && mode_reg != MODE_IDLE) begin
            if (period_cnt_reg != '0) begin
                period_cnt_next = period_cnt_reg - PERIOD_W'(1);
            end else if (mode_reg == MODE_RLOAD) begin
                if (replay_ptr_reg == '0) begin
                    hist_cnt_next = '0;
                    mode_next     = MODE_IDLE;
                    ack           = pend_ack_reg;
                    pend_ack_next = 1'b0;
                end else begin
                    // hist_rd_data_reg already holds the entry below the pointer.
                    replay_ptr_next = replay_ptr_dec;
                    mode_next       = MODE_RMOVE;
                    dir_next        = replay_dir;
                    step_idx_next   = '0;
                    target_next     = replay_dir[1] ? horz_steps_reg : vert_steps_reg;
                    period_cnt_next = '0;
                end
            end else if (mode_reg == MODE_HOMEH && lim_h) begin
                mode_next     = MODE_HOMEV;
                dir_next      = DIR_DOWN;
                step_idx_next = '0;
                target_next   = STEPS_W'(home_chunk_reg);
            end else if (mode_reg == MODE_HOMEV && lim_v) begin
                mode_next     = MODE_LEFT;
                dir_next      = DIR_LEFT;
                step_idx_next = '0;
                target_next   = full_width_reg;
            end else begin
                logic end_now;
                logic completed;
                end_now   = 1'b0;
                completed = 1'b0;
                if (step_done) begin
                    end_now   = 1'b1;
                    completed = 1'b1;
                end else begin
                    if (step_idx_reg == '0) begin
                        enable_next = 1'b1;
                    end
                    // A limit stop leaves the driver enabled.
                    if ((dir_reg == DIR_DOWN && lim_v) || (dir_reg == DIR_RIGHT && lim_h)) begin
                        end_now = 1'b1;
                    end
                end

                if (end_now) begin
                    if (completed) begin
                        enable_next = 1'b0;
                    end
                    case (mode_reg)
                        MODE_MOVE: begin
                            if (hist_cnt_reg < HIST_CNT_W'(HIST_DEPTH)) begin
                                hist_we       = 1'b1;
                                hist_cnt_next = hist_cnt_reg + HIST_CNT_W'(1);
                            end else begin
                                drop = 1'b1;
                            end
                            ack           = pend_ack_reg;
                            pend_ack_next = 1'b0;
                            mode_next     = MODE_IDLE;
                        end
                        MODE_RMOVE: mode_next = MODE_RLOAD;
                        MODE_HOMEH, MODE_HOMEV: begin
                            step_idx_next   = '0;
                            period_cnt_next = '0;
                        end
                        default: mode_next = MODE_IDLE;
                    endcase
                end else begin
                    if (dir_reg[1]) begin
                        coils_h_next = pat;
                        coils_v_next = 4'd0;
                    end else begin
                        coils_h_next = 4'd0;
                        coils_v_next = pat;
                    end
                    step_idx_next = step_idx_reg + INDEX_W'(1);
                    if (mode_reg == MODE_FAST || step_period_reg == '0) begin
                        period_cnt_next = '0;
                    end else begin
                        period_cnt_next = step_period_reg - PERIOD_W'(1);
                    end
                end
            end
        end
    end

    // The read address follows the next replay pointer, so the data is ready in the following cycle.
    always_comb begin
        if (replay_ptr_next == '0) begin
            hist_rd_addr = '0;
        end else begin
            hist_rd_addr = HIST_ADDR_W'(replay_ptr_next - HIST_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_wr_addr] <= dir_reg;
        end
        hist_rd_data_reg <= hist_mem[hist_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            dir_reg        <= DIR_UP;
            step_idx_reg   <= '0;
            target_reg     <= '0;
            period_cnt_reg <= '0;
            hist_cnt_reg   <= '0;
            replay_ptr_reg <= '0;
            pend_ack_reg   <= 1'b0;
            coils_h_reg    <= '0;
            coils_v_reg    <= '0;
            enable_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            dir_reg        <= dir_next;
            step_idx_reg   <= step_idx_next;
            target_reg     <= target_next;
            period_cnt_reg <= period_cnt_next;
            hist_cnt_reg   <= hist_cnt_next;
            replay_ptr_reg <= replay_ptr_next;
            pend_ack_reg   <= pend_ack_next;
            coils_h_reg    <= coils_h_next;
            coils_v_reg    <= coils_v_next;
            enable_reg     <= enable_next;
            if (in_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= {4'd0, drop, (mode_next != MODE_IDLE), ack, enable_next,
                           coils_v_next, coils_h_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // An idle sequencer always leaves its step timer cleared.
    a_idle_timer_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_IDLE) |-> (period_cnt_reg == '0))
        else $error("step timer not clear while idle");

    a_hist_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (hist_cnt_reg <= HIST_CNT_W'(HIST_DEPTH)) && (replay_ptr_reg <= hist_cnt_reg))
        else $error("history count or replay pointer out of range");

    // History is written only at the end of a recorded move, never during replay.
    a_hist_write_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_we |-> (mode_reg == MODE_MOVE && in_accept))
        else $error("history written outside a recorded move");

    a_step_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_IDLE && mode_reg != MODE_RLOAD)
            |-> (step_idx_reg <= {1'b0, target_reg} + INDEX_W'(1)))
        else $error("step index ran past its target");

endmodule

`default_nettype wire

FILE: sim/tb_two_axis_stepper_command_sequencer_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two-axis stepper command sequencer.
// It predicts the coil, enable, acknowledge, busy and dropped outputs of every transaction
// and compares them with the block. Depends on tasc_pkg and two_axis_stepper_command_sequencer_unit.

module tb_two_axis_stepper_command_sequencer_unit;
    import tasc_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 40;
    // Full-step patterns 5, 6, 10, 9 packed from phase 0 upward.
    localparam logic [15:0] COIL_SEQ = 16'h9A65;

    typedef struct packed {
        logic       dropped;
        logic       busy;
        logic       ack;
        logic       enable;
        logic [3:0] coils_v;
        logic [3:0] coils_h;
    } drive_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;

    // Predicted register settings.
    logic [15:0] cfg_period = 16'd5;
    logic [11:0] cfg_vsteps = 12'd178;
    logic [11:0] cfg_hsteps = 12'd191;
    logic [11:0] cfg_width  = 12'd1720;
    logic [7:0]  cfg_chunk  = 8'd10;

    // Predicted sequencer state.
    mode_t       st_mode = MODE_IDLE;
    dir_t        st_dir = DIR_UP;
    logic [12:0] st_idx = '0;
    logic [11:0] st_target = '0;
    logic [15:0] st_pcnt = '0;
    dir_t        st_hist [HIST_DEPTH];
    int          st_hcnt = 0;
    int          st_rptr = 0;
    bit          st_pending = 1'b0;
    logic [3:0]  st_coil_h = '0;
    logic [3:0]  st_coil_v = '0;
    bit          st_en = 1'b0;
    bit          res_ack, res_drop;

    drive_word_t pending_drives [$];

    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int rx_stall = 0;
    int n_cycles = 0;
    int n_sent = 0;
    int n_cmds = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_settings = 0;

    two_axis_stepper_command_sequencer_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("two_axis_stepper_command_sequencer_unit regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [11:0] steps_for(input dir_t d);
        return d[1] ? cfg_hsteps : cfg_vsteps;
    endfunction

    function automatic void launch_move(input mode_t m, input dir_t d, input logic [11:0] tgt);
        st_mode   = m;
        st_dir    = d;
        st_idx    = '0;
        st_target = tgt;
        st_pcnt   = '0;
    endfunction

    function automatic void close_move(input bit completed);
        if (completed)
            st_en = 1'b0;
        case (st_mode)
            MODE_MOVE: begin
                if (st_hcnt < HIST_DEPTH) begin
                    st_hist[HIST_ADDR_W'(st_hcnt)] = st_dir;
                    st_hcnt++;
                end else begin
                    res_drop = 1'b1;
                end
                if (st_pending)
                    res_ack = 1'b1;
                st_pending = 1'b0;
                st_mode = MODE_IDLE;
            end
            MODE_RMOVE: st_mode = MODE_RLOAD;
            MODE_HOMEH, MODE_HOMEV: begin
                // A homing chunk that ends just restarts; the mode moves on at the limit.
                st_idx  = '0;
                st_pcnt = '0;
            end
            default: st_mode = MODE_IDLE;
        endcase
    endfunction

    function automatic drive_word_t expected_drive(input bit is_cmd, input logic [7:0] ch,
                                                   input bit lh, input bit lv);
        drive_word_t r;
        dir_t d;
        logic [1:0] ph;
        logic [3:0] pat;
        res_ack  = 1'b0;
        res_drop = 1'b0;
        if (is_cmd) begin
            if (st_mode != MODE_IDLE) begin
                res_drop = 1'b1;
            end else begin
                st_pending = 1'b0;
                case (ch)
                    CHAR_UP, CHAR_DOWN, CHAR_LEFT, CHAR_RIGHT: begin
                        d = (ch == CHAR_UP) ? DIR_UP : (ch == CHAR_DOWN) ? DIR_DOWN :
                            (ch == CHAR_LEFT) ? DIR_LEFT : DIR_RIGHT;
                        launch_move(MODE_MOVE, d, steps_for(d));
                        st_pending = 1'b1;
                    end
                    CHAR_REPLAY: begin
                        st_mode    = MODE_RLOAD;
                        st_rptr    = st_hcnt;
                        st_pcnt    = '0;
                        st_pending = 1'b1;
                    end
                    CHAR_HOME: launch_move(MODE_HOMEH, DIR_RIGHT, {4'd0, cfg_chunk});
                    default:   launch_move(MODE_FAST, DIR_UP, 12'd3);
                endcase
            end
        end else if (st_mode != MODE_IDLE) begin
            if (st_pcnt != 0) begin
                st_pcnt--;
            end else if (st_mode == MODE_RLOAD) begin
                if (st_rptr == 0 || st_rptr > HIST_DEPTH) begin
                    st_hcnt = 0;
                    st_rptr = 0;
                    st_mode = MODE_IDLE;
                    if (st_pending)
                        res_ack = 1'b1;
                    st_pending = 1'b0;
                end else begin
                    // Replay runs newest first, each move in the opposite direction.
                    st_rptr--;
                    d = st_hist[HIST_ADDR_W'(st_rptr)] ^ 2'd1;
                    launch_move(MODE_RMOVE, d, steps_for(d));
                end
            end else if (st_mode == MODE_HOMEH && lh) begin
                launch_move(MODE_HOMEV, DIR_DOWN, {4'd0, cfg_chunk});
            end else if (st_mode == MODE_HOMEV && lv) begin
                launch_move(MODE_LEFT, DIR_LEFT, cfg_width);
            end else if (st_idx > {1'b0, st_target}) begin
                close_move(1'b1);
            end else begin
                if (st_idx == 0)
                    st_en = 1'b1;
                d = st_dir;
                if ((d == DIR_DOWN && lv) || (d == DIR_RIGHT && lh)) begin
                    close_move(1'b0);
                end else begin
                    ph = st_idx[1:0];
                    if (d[1] ^ d[0])
                        ph = 2'd3 - ph;
                    pat = COIL_SEQ[ph*4 +: 4];
                    if (d[1]) begin
                        st_coil_h = pat;
                        st_coil_v = 4'd0;
                    end else begin
                        st_coil_h = 4'd0;
                        st_coil_v = pat;
                    end
                    st_idx++;
                    st_pcnt = (st_mode == MODE_FAST || cfg_period == 16'd0) ? 16'd0
                                                                          : cfg_period - 16'd1;
                end
            end
        end
        r.coils_h = st_coil_h;
        r.coils_v = st_coil_v;
        r.enable  = st_en;
        r.ack     = res_ack;
        r.busy    = (st_mode != MODE_IDLE);
        r.dropped = res_drop;
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int expv, input int gotv);
        n_errors++;
        if (n_errors <= 40)
            $display("MISMATCH result %0d: %s expected %0d got %0d", n_checked, what, expv, gotv);
    endtask

    always @(posedge aclk) begin : result_check
        drive_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[11:0];
            if (pending_drives.size() == 0) begin
                report_mismatch("unexpected result", 0, got);
            end else begin
                want = pending_drives.pop_front();
                if (got.coils_h != want.coils_h)
                    report_mismatch("coils_horizontal", want.coils_h, got.coils_h);
                if (got.coils_v != want.coils_v)
                    report_mismatch("coils_vertical", want.coils_v, got.coils_v);
                if (got.enable != want.enable)
                    report_mismatch("driver_enable", want.enable, got.enable);
                if (got.ack != want.ack)
                    report_mismatch("send_ack", want.ack, got.ack);
                if (got.busy != want.busy)
                    report_mismatch("busy_res", want.busy, got.busy);
                if (got.dropped != want.dropped)
                    report_mismatch("dropped", want.dropped, got.dropped);
            end
            n_checked++;
            rx_stall = rx_idle_on ? $urandom_range(0, 15) : 0;
        end
    end

    always @(negedge aclk) begin
        if (rx_stall != 0) begin
            m_tready = 1'b0;
            rx_stall--;
        end else begin
            m_tready = 1'b1;
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_item(input bit is_cmd, input logic [7:0] ch, input bit lh, input bit lv);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = is_cmd;
        s_tdata  = {6'd0, lv, lh, ch};
        do @(posedge aclk); while (!s_tready);
        pending_drives.push_back(expected_drive(is_cmd, ch, lh, lv));
        n_sent++;
        if (is_cmd)
            n_cmds++;
    endtask

    // Ticks until the sequencer is idle again; each limit is set with a chance of one in odds.
    // With noisy set, commands are sometimes thrown in while busy.
    task automatic settle(input int odds, input bit noisy);
        while (st_mode != MODE_IDLE) begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_item(1'b1, 8'($urandom), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            else
                send_item(1'b0, 8'($urandom), $urandom_range(1, odds) == 1,
                          $urandom_range(1, odds) == 1);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_drives.size() != 0 && guard < 2000) begin
            @(posedge aclk);
            guard++;
        end
        if (pending_drives.size() != 0) begin
            report_mismatch("missing results", pending_drives.size(), 0);
            pending_drives.delete();
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input reg_idx_t idx, output logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        value = prdata;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_register(input reg_idx_t idx, input logic [31:0] want);
        logic [31:0] got;
        apb_read(idx, got);
        if (got !== want)
            report_mismatch("register readback", int'(want), int'(got));
    endtask

    task automatic configure(input int period, input int vs, input int hs, input int fw,
                             input int hc);
        settle(4, 1'b0);
        drain();
        apb_write(REG_STEP_PERIOD, 32'(period));
        apb_write(REG_VERT_STEPS, 32'(vs));
        apb_write(REG_HORZ_STEPS, 32'(hs));
        apb_write(REG_FULL_WIDTH, 32'(fw));
        apb_write(REG_HOME_CHUNK, 32'(hc));
        cfg_period = 16'(period);
        cfg_vsteps = 12'(vs);
        cfg_hsteps = 12'(hs);
        cfg_width  = 12'(fw);
        cfg_chunk  = 8'(hc);
        n_settings++;
    endtask

    // ---------------------------------------------------------------- tests

    // Register values after reset, read back and exercised by moves that end at a limit.
    task automatic test_reset_values();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        check_register(REG_STEP_PERIOD, 32'd5);
        check_register(REG_VERT_STEPS, 32'd178);
        check_register(REG_HORZ_STEPS, 32'd191);
        check_register(REG_FULL_WIDTH, 32'd1720);
        check_register(REG_HOME_CHUNK, 32'd10);
        repeat (3) send_item(1'b0, 8'($urandom), 1'b0, 1'b0);
        send_item(1'b1, CHAR_DOWN, 1'b0, 1'b1);
        settle(1, 1'b0);
        send_item(1'b1, CHAR_RIGHT, 1'b0, 1'b0);
        settle(3, 1'b0);
    endtask

    task automatic test_directed_commands();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        configure(2, 1, 2, 3, 1);
        send_item(1'b1, CHAR_UP, 1'b0, 1'b0);
        settle(100000, 1'b0);
        send_item(1'b1, CHAR_DOWN, 1'b0, 1'b0);
        settle(100000, 1'b0);
        send_item(1'b1, CHAR_LEFT, 1'b1, 1'b1);
        settle(100000, 1'b0);
        send_item(1'b1, CHAR_RIGHT, 1'b0, 1'b0);
        settle(100000, 1'b0);
        // Down move with the vertical limit already reached: stops before any step.
        send_item(1'b1, CHAR_DOWN, 1'b0, 1'b1);
        settle(1, 1'b0);
        // Right move that is likely to hit the horizontal limit part way.
        send_item(1'b1, CHAR_RIGHT, 1'b0, 1'b0);
        settle(3, 1'b0);
        send_item(1'b1, CHAR_REPLAY, 1'b0, 1'b0);
        settle(100000, 1'b0);
        // Replay with an empty history acknowledges on the next tick.
        send_item(1'b1, CHAR_REPLAY, 1'b0, 1'b0);
        settle(100000, 1'b0);
        send_item(1'b1, CHAR_HOME, 1'b0, 1'b0);
        settle(3, 1'b0);
        send_item(1'b1, 8'h00, 1'b0, 1'b0);
        settle(100000, 1'b0);
        send_item(1'b1, 8'hFF, 1'b1, 1'b1);
        settle(100000, 1'b0);
        // A command that arrives while a move runs is dropped.
        send_item(1'b1, CHAR_UP, 1'b0, 1'b0);
        send_item(1'b1, CHAR_LEFT, 1'b0, 1'b0);
        settle(100000, 1'b0);
        send_item(1'b0, 8'hFF, 1'b1, 1'b1);
    endtask

    // Fills the history past its depth, then replays and clears it.
    task automatic test_history_overflow();
        configure(1, 0, 0, 0, 0);
        send_item(1'b1, CHAR_REPLAY, 1'b0, 1'b0);
        settle(100000, 1'b0);
        repeat (HIST_DEPTH + 2) begin
            send_item(1'b1, CHAR_UP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            settle(2, 1'b0);
        end
        send_item(1'b1, CHAR_REPLAY, 1'b0, 1'b0);
        settle(4, 1'b0);
    endtask

    task automatic test_period_extremes();
        configure(0, 2, 2, 1, 1);
        send_item(1'b1, CHAR_UP, 1'b0, 1'b0);
        settle(100000, 1'b0);
        send_item(1'b1, CHAR_RIGHT, 1'b0, 1'b0);
        settle(100000, 1'b0);
        send_item(1'b1, CHAR_HOME, 1'b0, 1'b0);
        settle(3, 1'b0);
        send_item(1'b1, 8'h78, 1'b0, 1'b0);
        settle(100000, 1'b0);
        // A long period counted out in full.
        configure(100, 0, 0, 0, 0);
        send_item(1'b1, CHAR_UP, 1'b0, 1'b0);
        settle(100000, 1'b0);
        // The longest period only with operations that never wait on it.
        configure(65535, 0, 0, 0, 0);
        send_item(1'b1, CHAR_DOWN, 1'b0, 1'b1);
        settle(1, 1'b0);
        send_item(1'b1, 8'h01, 1'b0, 1'b0);
        settle(100000, 1'b0);
    endtask

    // Largest step counts, with the moves cut short at the limits.
    task automatic test_step_extremes();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        configure(1, 4095, 4095, 5, 255);
        send_item(1'b1, CHAR_DOWN, 1'b0, 1'b0);
        settle(8, 1'b0);
        send_item(1'b1, CHAR_HOME, 1'b0, 1'b0);
        settle(8, 1'b0);
        send_item(1'b1, CHAR_RIGHT, 1'b0, 1'b0);
        settle(8, 1'b0);
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int phase_start, lim_odds;
        logic [7:0] ch;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 0)
                configure(0, 0, 0, 0, 0);
            else
                configure($urandom_range(0, 3), $urandom_range(0, 12), $urandom_range(0, 12),
                          $urandom_range(0, 20), $urandom_range(0, 4));
            lim_odds = $urandom_range(0, 1) ? 3 : 25;
            phase_start = n_sent;
            while (n_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 85) begin
                    case ($urandom_range(0, 6))
                        0:       ch = CHAR_UP;
                        1:       ch = CHAR_DOWN;
                        2:       ch = CHAR_LEFT;
                        3:       ch = CHAR_RIGHT;
                        4:       ch = CHAR_REPLAY;
                        5:       ch = CHAR_HOME;
                        default: ch = 8'($urandom);
                    endcase
                    send_item(1'b1, ch, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    settle(lim_odds, 1'b1);
                end else begin
                    send_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_values();
        test_directed_commands();
        test_history_overflow();
        test_period_extremes();
        test_step_extremes();
        test_random_traffic();
        drain();
        $display("Summary: %0d input transactions (%0d command bytes), %0d results checked.",
                 n_sent, n_cmds, n_checked);
        $display("Covered %0d register settings, limit stops, homing, replay and history overflow.",
                 n_settings);
        if (n_errors == 0)
            $display("two_axis_stepper_command_sequencer_unit regression: pass");
        else
            $display("two_axis_stepper_command_sequencer_unit regression: fail");
        $finish;
    end

endmodule
